FILE: rtl/sqe_pkg.sv
`timescale 1ns / 1ps
package sqe_pkg;

  // item selector codes
  localparam logic [1:0] FUNC_BEGIN  = 2'd0;
  localparam logic [1:0] FUNC_DATA   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [15:0] BUF_SIZE_RESET = 16'd4096;

  // space needed for one character and for a pair, terminator included
  localparam logic [15:0] NEED_SINGLE = 16'd2;
  localparam logic [15:0] NEED_PAIR   = 16'd3;

  // command queue depth, a power of two
  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);

  typedef logic [CMD_AW-1:0] cmd_ptr_t;
  typedef logic [CMD_AW:0]   cmd_cnt_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_N         = 8'h6e;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_V         = 8'h76;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_VT        = 8'h0b;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7e;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_SINGLE,
    OP_PAIR,
    OP_HEX
  } op_t;

  // classified request: pair emits backslash then c2, hex emits
  // backslash, x, c1, c2, single and begin emit c1
  typedef struct packed {
    op_t        op;
    logic [7:0] c1;
    logic [7:0] c2;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        last;
    logic        err;
    logic [15:0] used;
  } result_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] v;
    v = {4'b0000, n};
    if (n < 4'd10) return 8'h30 + v;
    else return 8'h57 + v;
  endfunction

endpackage

FILE: rtl/sqe_front.sv
`timescale 1ns / 1ps
module sqe_front import sqe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] func,
  input  logic [7:0] data_byte,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  cmd_t       queue [CMD_DEPTH];
  cmd_ptr_t   wr_ptr;
  cmd_ptr_t   rd_ptr;
  cmd_cnt_t   count;
  cmd_t       cls;
  logic       wr_en;
  logic       rd_en;

  // classify the incoming request
  always_comb begin
    cls.op = OP_SINGLE;
    cls.c1 = CH_QUOTE;
    cls.c2 = CH_NUL;
    case (func)
      FUNC_BEGIN: begin
        cls.op = OP_BEGIN;
      end
      FUNC_DATA: begin
        if (data_byte == CH_NUL) begin
          cls.op = OP_SINGLE;
        end else if (data_byte == CH_LF) begin
          cls.op = OP_PAIR;
          cls.c2 = CH_N;
        end else if (data_byte == CH_CR) begin
          cls.op = OP_PAIR;
          cls.c2 = CH_R;
        end else if (data_byte == CH_TAB) begin
          cls.op = OP_PAIR;
          cls.c2 = CH_T;
        end else if (data_byte == CH_VT) begin
          cls.op = OP_PAIR;
          cls.c2 = CH_V;
        end else if (data_byte == CH_BACKSLASH) begin
          cls.op = OP_PAIR;
          cls.c2 = CH_BACKSLASH;
        end else if (data_byte == CH_QUOTE) begin
          cls.op = OP_PAIR;
          cls.c2 = CH_QUOTE;
        end else if (data_byte >= CH_PRINT_LO && data_byte <= CH_PRINT_HI) begin
          cls.op = OP_SINGLE;
          cls.c1 = data_byte;
        end else begin
          cls.op = OP_HEX;
          cls.c1 = hex_digit(data_byte[7:4]);
          cls.c2 = hex_digit(data_byte[3:0]);
        end
      end
      default: begin
        cls.op = OP_SINGLE;
      end
    endcase
  end

  assign full      = (count == cmd_cnt_t'(CMD_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign wr_en     = push && !full && (func != FUNC_NONE);
  assign rd_en     = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + cmd_ptr_t'(1);
      if (rd_en) rd_ptr <= rd_ptr + cmd_ptr_t'(1);
      case ({wr_en, rd_en})
        2'b10:   count <= count + cmd_cnt_t'(1);
        2'b01:   count <= count - cmd_cnt_t'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/sqe_back.sv
`timescale 1ns / 1ps
module sqe_back import sqe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] buffer_size,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        empty,
  input  logic        pop,
  output result_t     res_out
);

  logic [1:0]  step;
  logic [1:0]  step_next;
  logic [15:0] count;
  logic [15:0] count_next;
  logic        failed;
  logic        failed_next;
  logic [15:0] count_inc;
  logic [15:0] diff;
  logic        room_single;
  logic        room_pair;
  logic        fire;
  result_t     res;

  result_t     ofifo [2];
  logic        owr;
  logic        ord;
  logic [1:0]  ocount;
  logic        can_write;
  logic        opop;

  assign can_write   = (ocount != 2'd2);
  assign fire        = cmd_valid && can_write;
  assign count_inc   = count + 16'd1;
  assign diff        = buffer_size - count;
  assign room_single = (count < buffer_size) && (diff >= NEED_SINGLE);
  assign room_pair   = (count < buffer_size) && (diff >= NEED_PAIR);

  // one result per cycle while a command waits and the result queue has room
  always_comb begin
    step_next    = step;
    count_next   = count;
    failed_next  = failed;
    cmd_pop      = 1'b0;
    res.out_char = CH_NUL;
    res.last     = 1'b1;
    res.err      = 1'b1;
    res.used     = count;
    if (fire) begin
      case (cmd.op)
        OP_BEGIN: begin
          cmd_pop = 1'b1;
          if (buffer_size >= NEED_SINGLE) begin
            count_next   = 16'd1;
            failed_next  = 1'b0;
            res.out_char = CH_QUOTE;
            res.err      = 1'b0;
            res.used     = 16'd1;
          end else begin
            count_next  = '0;
            failed_next = 1'b1;
            res.used    = '0;
          end
        end
        OP_SINGLE: begin
          cmd_pop = 1'b1;
          if (!failed && room_single) begin
            count_next   = count_inc;
            res.out_char = cmd.c1;
            res.err      = 1'b0;
            res.used     = count_inc;
          end else begin
            failed_next = 1'b1;
          end
        end
        default: begin
          // pair and hex escapes
          case (step)
            2'd0: begin
              if (!failed && room_pair) begin
                count_next   = count_inc;
                res.out_char = CH_BACKSLASH;
                res.err      = 1'b0;
                res.last     = 1'b0;
                res.used     = count_inc;
                step_next    = 2'd1;
              end else begin
                failed_next = 1'b1;
                cmd_pop     = 1'b1;
              end
            end
            2'd1: begin
              count_next = count_inc;
              res.err    = 1'b0;
              res.used   = count_inc;
              if (cmd.op == OP_HEX) begin
                res.out_char = CH_X;
                res.last     = 1'b0;
                step_next    = 2'd2;
              end else begin
                res.out_char = cmd.c2;
                cmd_pop      = 1'b1;
                step_next    = 2'd0;
              end
            end
            2'd2: begin
              if (room_pair) begin
                count_next   = count_inc;
                res.out_char = cmd.c1;
                res.err      = 1'b0;
                res.last     = 1'b0;
                res.used     = count_inc;
                step_next    = 2'd3;
              end else begin
                failed_next = 1'b1;
                cmd_pop     = 1'b1;
                step_next   = 2'd0;
              end
            end
            default: begin
              count_next   = count_inc;
              res.out_char = cmd.c2;
              res.err      = 1'b0;
              res.used     = count_inc;
              cmd_pop      = 1'b1;
              step_next    = 2'd0;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      count  <= '0;
      failed <= 1'b0;
    end else begin
      step   <= step_next;
      count  <= count_next;
      failed <= failed_next;
    end
  end

  // two-entry result queue
  assign empty   = (ocount == 2'd0);
  assign opop    = pop && !empty;
  assign res_out = ofifo[ord];

  always_ff @(posedge clk) begin
    if (fire) begin
      ofifo[owr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= '0;
    end else begin
      if (fire) owr <= ~owr;
      if (opop) ord <= ~ord;
      case ({fire, opop})
        2'b10:   ocount <= ocount + 2'd1;
        2'b01:   ocount <= ocount - 2'd1;
        default: ocount <= ocount;
      endcase
    end
  end

endmodule

FILE: rtl/string_quote_escaper.sv
`timescale 1ns / 1ps
// string_quote_escaper: turns a byte stream into a double-quoted, C-style
// escaped string, one character per result, while counting the characters
// against a buffer of buffer_size bytes (terminator included). func 0 begins
// a string (clears the count, emits the opening quote), func 1 feeds a data
// byte, func 2 or a data byte of zero emits the closing quote, func 3 is
// dropped without a result. Printable bytes pass through, newline, return,
// tab, vertical tab, backslash and quote become two-character escapes, all
// other bytes become \xhh with lower-case hex. A character needs two bytes
// of free space and a pair three; when a check fails an error result (zero
// character, error set) is emitted and every later request except a begin
// yields a single error result. last_of_run marks the final result of each
// request. used_length is the count after the character, or before the
// failed append on an error result.
// Timing: the front classifies one request per cycle into a 4-entry command
// queue while it is not full; the back sequencer writes one result per cycle
// into a 2-entry result queue while that queue has room, so a request yields
// one result (plain character, quote, error), two (two-character escape) or
// four (hex escape, three when its second pair does not fit), and sustained
// throughput is one result per cycle while pop is held high. A request
// passes through the command queue and then the result queue before its
// first result can be popped.
// buffer_size is written through cfg_valid/cfg_ready/cfg_data; the user must write it
// only while the block is idle, the block itself does not enforce it; cfg_ready is always high.
module string_quote_escaper import sqe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [7:0]  data_byte,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char,
  output logic        last_of_run,
  output logic        error,
  output logic [15:0] used_length,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] buffer_size;
  logic        cmd_valid;
  cmd_t        cmd;
  logic        cmd_pop;
  result_t     res;

  // buffer size register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUF_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      buffer_size <= cfg_data;
    end
  end

  // front: classify and queue
  sqe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .data_byte (data_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: space checks, emission and result queue
  sqe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .buffer_size (buffer_size),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .res_out     (res)
  );

  assign out_char    = res.out_char;
  assign last_of_run = res.last;
  assign error       = res.err;
  assign used_length = res.used;

endmodule

FILE: tb/escape_checker.sv
`timescale 1ns / 1ps
module escape_checker import sqe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  func,
  input  logic [7:0]  data_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_char,
  input  logic        last_of_run,
  input  logic        error,
  input  logic [15:0] used_length,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int REPORT_CAP = 100;

  logic [15:0] cap_bytes;
  logic [15:0] char_count;
  logic        str_failed;
  result_t     exp_chars[$];
  result_t     run_chars[$];
  int          errors;

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return 8'h61 + {4'd0, n} - 8'd10;
  endfunction

  function automatic bit fits(input logic [15:0] need);
    if (char_count >= cap_bytes) return 1'b0;
    return (cap_bytes - char_count) >= need;
  endfunction

  task automatic push_char(input logic [7:0] c, input logic err);
    result_t r;
    r.out_char = c;
    r.last     = 1'b0;
    r.err      = err;
    r.used     = char_count;
    run_chars.push_back(r);
  endtask

  // one or two characters, space checked once for the whole group
  task automatic append_chars(input bit two, input logic [7:0] c1, input logic [7:0] c2);
    if (!fits(two ? NEED_PAIR : NEED_SINGLE)) begin
      str_failed = 1'b1;
      push_char(CH_NUL, 1'b1);
    end else begin
      char_count = char_count + 16'd1;
      push_char(c1, 1'b0);
      if (two) begin
        char_count = char_count + 16'd1;
        push_char(c2, 1'b0);
      end
    end
  endtask

  task automatic predict_escape(input logic [1:0] f, input logic [7:0] b);
    result_t tail;
    run_chars.delete();
    case (f)
      FUNC_BEGIN: begin
        char_count = '0;
        str_failed = 1'b0;
        append_chars(1'b0, CH_QUOTE, CH_NUL);
      end
      FUNC_DATA, FUNC_FINISH: begin
        if (str_failed) begin
          push_char(CH_NUL, 1'b1);
        end else if (f == FUNC_FINISH || b == CH_NUL) begin
          append_chars(1'b0, CH_QUOTE, CH_NUL);
        end else begin
          case (b)
            CH_LF:        append_chars(1'b1, CH_BACKSLASH, CH_N);
            CH_CR:        append_chars(1'b1, CH_BACKSLASH, CH_R);
            CH_TAB:       append_chars(1'b1, CH_BACKSLASH, CH_T);
            CH_VT:        append_chars(1'b1, CH_BACKSLASH, CH_V);
            CH_BACKSLASH: append_chars(1'b1, CH_BACKSLASH, CH_BACKSLASH);
            CH_QUOTE:     append_chars(1'b1, CH_BACKSLASH, CH_QUOTE);
            default: begin
              if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
                append_chars(1'b0, b, CH_NUL);
              end else begin
                // hex escape: two pair appends, each checked on its own
                append_chars(1'b1, CH_BACKSLASH, CH_X);
                if (!str_failed) append_chars(1'b1, nibble_char(b[7:4]), nibble_char(b[3:0]));
              end
            end
          endcase
        end
      end
      default: ;
    endcase
    if (run_chars.size() > 0) begin
      tail = run_chars.pop_back();
      tail.last = 1'b1;
      run_chars.push_back(tail);
    end
    foreach (run_chars[i]) exp_chars.push_back(run_chars[i]);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      if (errors < REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      cap_bytes  = BUF_SIZE_RESET;
      char_count = '0;
      str_failed = 1'b0;
      exp_chars.delete();
    end else begin
      if (pop && !empty) begin
        if (exp_chars.size() == 0) begin
          if (errors < REPORT_CAP)
            $display("%0t: unexpected result, expected none actual char %0h err %0b",
                     $time, out_char, error);
          errors++;
        end else begin
          want = exp_chars.pop_front();
          check_field("out_char", {8'd0, want.out_char}, {8'd0, out_char});
          check_field("last_of_run", {15'd0, want.last}, {15'd0, last_of_run});
          check_field("error", {15'd0, want.err}, {15'd0, error});
          check_field("used_length", want.used, used_length);
        end
      end
      if (cfg_valid && cfg_ready) cap_bytes = cfg_data;
      if (push && !full) predict_escape(func, data_byte);
    end
    fail_count <= errors;
    pending    <= exp_chars.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import sqe_pkg::*;

  // no correct run goes this long without a single request moving
  localparam int QUIET_LIMIT = 4000;
  // far beyond the length of a whole correct run, even with every stall
  localparam int RUN_LIMIT = 100000;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES = 300;
  // cycles to let pass after the last result before a register write or the verdict
  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic        empty;
  logic        pop;
  logic [7:0]  out_char;
  logic        last_of_run;
  logic        error;
  logic [15:0] used_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;

  // idling knobs, set per phase by the stimulus
  int idle_pct;
  int stall_pct;
  // bumped by the stimulus to ask the receiver for a long hold-off
  int hold_seq;
  int hold_seen;
  int quiet_cycles;
  int run_cycles;
  // requests sent that the block acts on (selector 3 not counted)
  int data_items;

  string_quote_escaper uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .data_byte   (data_byte),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .last_of_run (last_of_run),
    .error       (error),
    .used_length (used_length),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  escape_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .data_byte   (data_byte),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .last_of_run (last_of_run),
    .error       (error),
    .used_length (used_length),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // 12 ns period, first rising edge at 6 ns
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // cycles since any request moved on any channel
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // total cycles, so a block that never stops emitting cannot keep the run alive
  always @(posedge clk) begin
    run_cycles <= run_cycles + 1;
  end

  // watchdog: a hung block ends the run
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT || run_cycles >= RUN_LIMIT);
    $display("FAIL string_quote_escaper");
    $finish;
  end

  // result side: random stalls, plus a long hold-off counted here on request
  initial begin
    pop       = 1'b0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one request, idling at random first, and hold it until accepted
  task automatic send_item(input logic [1:0] f, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    func      <= f;
    data_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    if (f != FUNC_NONE) data_items++;
  endtask

  // stop sending and wait for every expected result, then let the block go quiet
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [15:0] size);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // string content: mostly printable, with escapes, hex bytes and the odd zero
  function automatic logic [7:0] text_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
    if (pick < 65) begin
      case ($urandom_range(5))
        0:       return CH_LF;
        1:       return CH_CR;
        2:       return CH_TAB;
        3:       return CH_VT;
        4:       return CH_BACKSLASH;
        default: return CH_QUOTE;
      endcase
    end
    if (pick < 96) return 8'($urandom_range(255));
    return CH_NUL;
  endfunction

  // mostly well-formed strings with random content, some noise and open strings
  task automatic random_items(input int n);
    int target;
    int len;
    int tail;
    target = data_items + n;
    while (data_items < target) begin
      if ($urandom_range(99) < 85) begin
        send_item(FUNC_BEGIN, 8'($urandom_range(255)));
        len = $urandom_range(10);
        repeat (len) send_item(FUNC_DATA, text_byte());
        tail = $urandom_range(99);
        if (tail < 60)
          send_item(FUNC_FINISH, 8'($urandom_range(255)));
        else if (tail < 80)
          send_item(FUNC_DATA, CH_NUL);
      end else begin
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [15:0] size,
                           input int n, input bit hold);
    settle();
    write_buffer_size(size);
    idle_pct  = idle;
    stall_pct = stall;
    // the sender keeps offering while the receiver holds off, so the block fills
    if (hold) hold_seq <= hold_seq + 1;
    random_items(n);
  endtask

  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    func       = FUNC_NONE;
    data_byte  = 8'h00;
    cfg_valid  = 1'b0;
    cfg_data   = 16'h0000;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_seq   = 0;
    data_items = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every character class at the reset buffer size
    idle_pct  = 20;
    stall_pct = 20;
    send_item(FUNC_BEGIN, 8'hff);
    send_item(FUNC_DATA, 8'h41);
    send_item(FUNC_DATA, CH_PRINT_LO);
    send_item(FUNC_DATA, CH_PRINT_HI);
    send_item(FUNC_DATA, CH_LF);
    send_item(FUNC_DATA, CH_CR);
    send_item(FUNC_DATA, CH_TAB);
    send_item(FUNC_DATA, CH_VT);
    send_item(FUNC_DATA, CH_BACKSLASH);
    send_item(FUNC_DATA, CH_QUOTE);
    // zero byte closes the string like a finish
    send_item(FUNC_DATA, CH_NUL);
    send_item(FUNC_DATA, 8'h7f);
    send_item(FUNC_DATA, 8'hff);
    send_item(FUNC_FINISH, 8'ha5);
    // unused selector is dropped
    send_item(FUNC_NONE, 8'h5a);
    // no closed state: data after finish still appends
    send_item(FUNC_DATA, 8'h7a);

    // opening quote does not fit, failure sticks until the next begin
    settle();
    write_buffer_size(16'd1);
    send_item(FUNC_BEGIN, 8'h00);
    send_item(FUNC_DATA, 8'h61);
    send_item(FUNC_FINISH, 8'h00);
    settle();
    write_buffer_size(16'd0);
    send_item(FUNC_BEGIN, 8'h00);

    // hex escape whose second pair runs out of space
    settle();
    write_buffer_size(16'd5);
    send_item(FUNC_BEGIN, 8'h00);
    send_item(FUNC_DATA, 8'h80);
    send_item(FUNC_DATA, 8'h62);

    // count already past a freshly shrunk buffer
    settle();
    write_buffer_size(16'd4);
    send_item(FUNC_BEGIN, 8'h00);
    send_item(FUNC_DATA, CH_LF);
    settle();
    write_buffer_size(16'd2);
    send_item(FUNC_DATA, 8'h65);

    // single character with only the terminator's byte left
    settle();
    write_buffer_size(16'd3);
    send_item(FUNC_BEGIN, 8'h00);
    send_item(FUNC_DATA, 8'h63);
    send_item(FUNC_DATA, 8'h64);

    // random phases: no idling, sender idle, receiver stalling with a hold-off, both
    run_phase(0, 0, 16'hffff, 40, 1'b0);
    run_phase(82, 0, 16'($urandom_range(40, 2)), 40, 1'b0);
    run_phase(0, 82, 16'd24, 40, 1'b1);
    run_phase(32, 32, 16'd3, 25, 1'b0);
    run_phase(32, 32, 16'($urandom_range(40, 2)), 40, 1'b0);
    run_phase(0, 0, 16'd2, 20, 1'b0);
    run_phase(32, 32, BUF_SIZE_RESET, 40, 1'b0);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS string_quote_escaper");
    end else begin
      $display("FAIL string_quote_escaper");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sqe_pkg.sv
rtl/sqe_front.sv
rtl/sqe_back.sv
rtl/string_quote_escaper.sv
tb/escape_checker.sv
tb/tb.sv
